FILE: design/svpwm_pkg.sv
// svpwm_pkg: shared constants, types and elaboration-time functions for the
// three-phase space-vector duty generator. No dependencies.
package svpwm_pkg;

    // angle and sine table geometry
    localparam int ANGLE_BITS       = 16;
    localparam int TABLE_INDEX_BITS = 11;
    localparam int ANGLE_PORT_W     = 16;
    localparam int RA_W             = TABLE_INDEX_BITS - 1;
    localparam int TAB_Q            = 2 ** (TABLE_INDEX_BITS - 2);

    localparam logic [ANGLE_BITS-1:0] SHIFT_0   = '0;
    localparam logic [ANGLE_BITS-1:0] SHIFT_120 = ANGLE_BITS'((2 ** ANGLE_BITS) / 3);
    localparam logic [ANGLE_BITS-1:0] SHIFT_240 = ANGLE_BITS'(2 * ((2 ** ANGLE_BITS) / 3));

    // field widths
    localparam int AMP_W  = 16;
    localparam int MAG_W  = 16;
    localparam int DUTY_W = 17;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd1;

    // queue sizes
    localparam int MID_DEPTH  = 4;
    localparam int MID_PTR_W  = $clog2(MID_DEPTH);
    localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int PIPE_STAGES = 5;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // one phase after classification: quarter-table address and sign
    typedef struct packed {
        logic [RA_W-1:0] addr;
        logic            neg;
    } phase_ref_t;

    // one queued item between front and back
    typedef struct packed {
        phase_ref_t [2:0] ph;
    } mid_item_t;

    // one finished result
    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
    } result_t;

    typedef logic [MAG_W-1:0] qrom_t [0:TAB_Q];

    // advance the angle, take the top index bits and fold into a quarter wave
    function automatic phase_ref_t phase_ref(logic [ANGLE_BITS-1:0] ang,
                                             logic [ANGLE_BITS-1:0] ofs);
        logic [ANGLE_BITS-1:0]                  a;
        logic [ANGLE_BITS+TABLE_INDEX_BITS-1:0] ext;
        logic [TABLE_INDEX_BITS-1:0]            idx;
        logic [RA_W-1:0]                        r;
        phase_ref_t                             res;
        a        = ang + ofs;
        ext      = {a, {TABLE_INDEX_BITS{1'b0}}};
        idx      = ext[ANGLE_BITS+TABLE_INDEX_BITS-1 -: TABLE_INDEX_BITS];
        r        = {1'b0, idx[TABLE_INDEX_BITS-3:0]};
        res.neg  = idx[TABLE_INDEX_BITS-1];
        res.addr = idx[TABLE_INDEX_BITS-2] ? (RA_W'(TAB_Q) - r) : r;
        return res;
    endfunction

    // (a*b) >> 62 truncated to 64 bits
    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // divide a series term by (2k)(2k+1)
    function automatic logic [63:0] div_term(logic [63:0] p, int k);
        logic [63:0] q;
        case (k)
            1:       q = p / 6;
            2:       q = p / 20;
            3:       q = p / 42;
            4:       q = p / 72;
            5:       q = p / 110;
            6:       q = p / 156;
            7:       q = p / 210;
            8:       q = p / 272;
            9:       q = p / 342;
            10:      q = p / 420;
            11:      q = p / 506;
            12:      q = p / 600;
            13:      q = p / 702;
            14:      q = p / 812;
            15:      q = p / 930;
            16:      q = p / 1056;
            17:      q = p / 1190;
            18:      q = p / 1332;
            19:      q = p / 1482;
            20:      q = p / 1640;
            21:      q = p / 1806;
            22:      q = p / 1980;
            23:      q = p / 2162;
            24:      q = p / 2352;
            25:      q = p / 2550;
            26:      q = p / 2756;
            27:      q = p / 2970;
            28:      q = p / 3192;
            29:      q = p / 3422;
            default: q = p;
        endcase
        return q;
    endfunction

    // round(32767*sin(pi/2 * r / TAB_Q)) by a fixed-point series
    function automatic logic [MAG_W-1:0] quarter_sine(int r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] res;
        int          k;
        x    = (PI_Q62 >> (TABLE_INDEX_BITS - 1)) * 64'(r);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (k = 1; k < 30; k++) begin
            if (term != 64'd0) begin
                term = div_term(mul_q62(term, x2), k);
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        res = ((sum >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
        return res[MAG_W-1:0];
    endfunction

    // quarter-wave sine table, filled at elaboration
    function automatic qrom_t build_qrom();
        qrom_t t;
        for (int i = 0; i <= TAB_Q; i++) begin
            t[i] = quarter_sine(i);
        end
        return t;
    endfunction

endpackage

FILE: design/svpwm_sine_rom.sv
// svpwm_sine_rom: quarter-wave sine table with one registered read port.
// Depends on svpwm_pkg for the table contents and widths.
module svpwm_sine_rom (
    input  logic                         clk,
    input  logic [svpwm_pkg::RA_W-1:0]   addr,
    output logic [svpwm_pkg::MAG_W-1:0]  data_reg
);
    import svpwm_pkg::*;

    localparam qrom_t SINE_QUARTER = build_qrom();

    // registered table read
    always_ff @(posedge clk)
    begin
        data_reg <= SINE_QUARTER[addr];
    end

endmodule

FILE: design/svpwm_front.sv
// svpwm_front: accepts angles, splits each into three phase table references
// and holds them in a short queue for the back end. Depends on svpwm_pkg.
module svpwm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [svpwm_pkg::ANGLE_PORT_W-1:0] angle,
    output logic                               head_valid,
    output svpwm_pkg::mid_item_t               head_item,
    input  logic                               head_pop
);
    import svpwm_pkg::*;

    mid_item_t              mem [0:MID_DEPTH-1];
    logic [MID_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [MID_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [MID_CNT_W-1:0]   count_reg, count_next;
    logic                   wr_en;
    logic                   rd_en;
    mid_item_t              new_item;

    // classify the incoming angle into three phase references
    always_comb
    begin
        new_item.ph[0] = phase_ref(angle[ANGLE_BITS-1:0], SHIFT_0);
        new_item.ph[1] = phase_ref(angle[ANGLE_BITS-1:0], SHIFT_120);
        new_item.ph[2] = phase_ref(angle[ANGLE_BITS-1:0], SHIFT_240);
    end

    assign full       = (count_reg == MID_CNT_W'(MID_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = head_pop && head_valid;

    // queue pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= new_item;
    end

    // the fill count stays in range and the pointers stay consistent with it
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MID_CNT_W'(MID_DEPTH))
        else $error("front queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != MID_CNT_W'(MID_DEPTH)) |->
        (wr_ptr_reg - rd_ptr_reg) == count_reg[MID_PTR_W-1:0])
        else $error("front queue pointers disagree with count");

endmodule

FILE: design/svpwm_back.sv
// svpwm_back: table lookup, amplitude scaling, min/max injection, short-pulse
// clamp and the result queue. Depends on svpwm_pkg and svpwm_sine_rom.
module svpwm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  svpwm_pkg::mid_item_t          head_item,
    output logic                          head_pop,
    input  logic [svpwm_pkg::AMP_W-1:0]   amplitude,
    input  logic [svpwm_pkg::AMP_W-1:0]   min_pulse,
    output logic                          empty,
    input  logic                          pop,
    output svpwm_pkg::result_t            result
);
    import svpwm_pkg::*;

    logic [PIPE_STAGES-1:0]    valid_reg;
    logic [MAG_W-1:0]          mag [0:2];
    logic [2:0]                s1_neg_reg;
    logic signed [31:0]        s2_prod_reg [0:2];
    logic signed [16:0]        s3_val_reg  [0:2];
    logic signed [16:0]        s3_lo_reg, s3_hi_reg;
    logic signed [16:0]        s4_val_reg  [0:2];
    logic signed [16:0]        s4_ofs_reg;
    logic signed [18:0]        s5_duty_reg [0:2];
    logic signed [16:0]        s3_val_w    [0:2];
    logic signed [16:0]        lo_w, hi_w;
    logic signed [17:0]        lohi_sum;
    logic signed [18:0]        lim_lo, lim_hi;
    logic [DUTY_W-1:0]         duty_w [0:2];
    result_t                   wr_data;

    result_t                   out_mem [0:OUT_DEPTH-1];
    logic [OUT_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0]      count_reg, count_next;
    logic [OUT_CNT_W-1:0]      credit_used;
    logic                      out_wr;
    logic                      out_rd;

    // take a queued item only if the result queue has room for it
    assign credit_used = count_reg + OUT_CNT_W'($countones(valid_reg));
    assign head_pop    = head_valid && (credit_used < OUT_CNT_W'(OUT_DEPTH));

    // stage 1: table lookup, one port per phase
    for (genvar p = 0; p < 3; p++)
    begin : g_rom
        svpwm_sine_rom u_rom (
            .clk      (clk),
            .addr     (head_item.ph[p].addr),
            .data_reg (mag[p])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], head_pop};
    end

    // stage 2: signed sine times amplitude
    always_ff @(posedge clk)
    begin
        s1_neg_reg <= {head_item.ph[2].neg, head_item.ph[1].neg, head_item.ph[0].neg};
        for (int i = 0; i < 3; i++)
        begin
            logic signed [16:0] sv;
            logic signed [33:0] prod;
            sv   = s1_neg_reg[i] ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]});
            prod = sv * $signed({1'b0, amplitude});
            s2_prod_reg[i] <= prod[31:0];
        end
    end

    // stage 3: floor shift and phase min / max
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s3_val_w[i] = s2_prod_reg[i][31:15];
        lo_w = s3_val_w[0];
        hi_w = s3_val_w[0];
        for (int i = 1; i < 3; i++)
        begin
            if (s3_val_w[i] < lo_w)
                lo_w = s3_val_w[i];
            if (s3_val_w[i] > hi_w)
                hi_w = s3_val_w[i];
        end
    end

    always_ff @(posedge clk)
    begin
        s3_val_reg <= s3_val_w;
        s3_lo_reg  <= lo_w;
        s3_hi_reg  <= hi_w;
    end

    // stage 4: injected offset, half the min plus max
    assign lohi_sum = 18'(s3_lo_reg) + 18'(s3_hi_reg);

    always_ff @(posedge clk)
    begin
        s4_val_reg <= s3_val_reg;
        s4_ofs_reg <= lohi_sum[17:1];
    end

    // stage 5: remove offset and center on half scale
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            s5_duty_reg[i] <= 19'(s4_val_reg[i]) - 19'(s4_ofs_reg) + 19'sd32768;
    end

    // short-pulse clamp on the way into the result queue
    assign lim_lo = $signed({3'b000, min_pulse});
    assign lim_hi = 19'sd65536 - $signed({3'b000, min_pulse});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (s5_duty_reg[i] < lim_lo)
                duty_w[i] = '0;
            else if (s5_duty_reg[i] > lim_hi)
                duty_w[i] = DUTY_W'(65536);
            else
                duty_w[i] = s5_duty_reg[i][DUTY_W-1:0];
        end
        wr_data.duty_a = duty_w[0];
        wr_data.duty_b = duty_w[1];
        wr_data.duty_c = duty_w[2];
    end

    // result queue
    assign out_wr = valid_reg[PIPE_STAGES-1];
    assign out_rd = pop && !empty;
    assign empty  = (count_reg == '0);
    assign result = out_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (out_wr && !out_rd)
            count_next = count_reg + 1'b1;
        else if (!out_wr && out_rd)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (out_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (out_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr)
            out_mem[wr_ptr_reg] <= wr_data;
    end

    // items in flight never exceed the result queue space
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue credit overrun");

    // a popped item reaches the first pipeline stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |=> valid_reg[0])
        else $error("popped item lost before lookup");

    // clamped duties stay within full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        out_wr |-> (wr_data.duty_a <= DUTY_W'(65536) && wr_data.duty_b <= DUTY_W'(65536)
                    && wr_data.duty_c <= DUTY_W'(65536)))
        else $error("duty above full scale");

endmodule

FILE: design/svpwm_three_phase_duty.sv
// svpwm_three_phase_duty: top level, configuration registers and the link
// between front end and back end. Depends on svpwm_pkg, svpwm_front, svpwm_back.
//
//   channel   handshake               payload
//   input     push / full             angle[15:0]
//   result    empty / pop             duty_a, duty_b, duty_c [16:0]
//   config    cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[15:0]
//
// One angle per cycle is taken while full is low; each transaction passes through
// the queue hop with table read, four arithmetic stages and the result queue write
// before it appears at the result side.
// The sine table read and the amplitude multiply each take one registered stage.
// Reset clears all queues and sets amplitude and min_pulse to zero.
// With pop held low the back end stops drawing once the result queue is spoken
// for, the front queue fills and full rises; cfg_ready is always high.
module svpwm_three_phase_duty (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [svpwm_pkg::ANGLE_PORT_W-1:0] angle,
    output logic                               empty,
    input  logic                               pop,
    output logic [svpwm_pkg::DUTY_W-1:0]       duty_a,
    output logic [svpwm_pkg::DUTY_W-1:0]       duty_b,
    output logic [svpwm_pkg::DUTY_W-1:0]       duty_c,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [svpwm_pkg::AMP_W-1:0]        cfg_data
);
    import svpwm_pkg::*;

    logic [AMP_W-1:0]  amplitude_reg;
    logic [AMP_W-1:0]  min_pulse_reg;
    logic              head_valid;
    logic              head_pop;
    mid_item_t         head_item;
    result_t           result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= '0;
            min_pulse_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AMPLITUDE: amplitude_reg <= cfg_data;
                REG_MIN_PULSE: min_pulse_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front end: accept and classify
    svpwm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .angle      (angle),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop)
    );

    // back end: compute and queue results
    svpwm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop),
        .amplitude  (amplitude_reg),
        .min_pulse  (min_pulse_reg),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign duty_a = result.duty_a;
    assign duty_b = result.duty_b;
    assign duty_c = result.duty_c;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for svpwm_three_phase_duty with an angle driver,
// a duty monitor and a duty predictor built on a local sine table.
// Depends on svpwm_pkg and the svpwm_three_phase_duty design files.
module tb_top;
    import svpwm_pkg::*;

    localparam int  CYCLE_LIMIT = 300000;
    localparam int  AMP_MAX     = 37813;
    localparam int  PULSE_MAX   = 32768;
    localparam int  HOLD_AT     = 300;
    localparam int  HOLD_CYCLES = 160;
    localparam int  SETTLE      = 20;
    localparam real HALF_PI     = 1.57079632679489661923;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    push      = 1'b0;
    logic                    full;
    logic [ANGLE_PORT_W-1:0] angle     = '0;
    logic                    empty;
    logic                    pop       = 1'b0;
    logic [DUTY_W-1:0]       duty_a;
    logic [DUTY_W-1:0]       duty_b;
    logic [DUTY_W-1:0]       duty_c;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [AMP_W-1:0]        cfg_data  = '0;

    // predictor state: register copies and quarter-wave sine table
    logic [AMP_W-1:0]        amp_reg   = '0;
    logic [AMP_W-1:0]        pulse_reg = '0;
    int                      quarter_wave [0:TAB_Q];

    logic [ANGLE_BITS-1:0]   angle_backlog [$];
    result_t                 duty_expect [$];
    logic [ANGLE_BITS-1:0]   edge_angles [12];
    int                      angles_issued = 0;
    int                      duties_seen   = 0;
    int                      fail_count    = 0;
    int                      cycle_count   = 0;
    int                      send_gap      = 0;
    int                      pop_gap       = 0;
    int                      backlog_hold  = 0;
    logic                    no_idle       = 1'b0;

    svpwm_three_phase_duty i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .angle     (angle),
        .empty     (empty),
        .pop       (pop),
        .duty_a    (duty_a),
        .duty_b    (duty_b),
        .duty_c    (duty_c),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // signed sine value for a full-circle table index
    function automatic longint sine_at(logic [TABLE_INDEX_BITS-1:0] idx);
        logic [1:0] quad;
        int         r;
        quad = idx[TABLE_INDEX_BITS-1 -: 2];
        r    = int'(idx[TABLE_INDEX_BITS-3:0]);
        case (quad)
            2'd0:    return longint'(quarter_wave[r]);
            2'd1:    return longint'(quarter_wave[TAB_Q - r]);
            2'd2:    return -longint'(quarter_wave[r]);
            default: return -longint'(quarter_wave[TAB_Q - r]);
        endcase
    endfunction

    // three scaled phases, min/max centering, then short pulse suppression
    function automatic result_t predict_duty(logic [ANGLE_BITS-1:0] ang);
        logic [ANGLE_BITS-1:0] turn;
        logic [ANGLE_BITS-1:0] phase_ofs [3];
        longint                level [3];
        logic [DUTY_W-1:0]     duty [3];
        longint                lo;
        longint                hi;
        longint                center;
        longint                d;
        phase_ofs = '{SHIFT_0, SHIFT_120, SHIFT_240};
        for (int k = 0; k < 3; k++)
        begin
            turn     = ang + phase_ofs[k];
            level[k] = (longint'(amp_reg) * sine_at(turn[ANGLE_BITS-1 -: TABLE_INDEX_BITS]))
                       >>> 15;
        end
        lo = level[0];
        hi = level[0];
        for (int k = 1; k < 3; k++)
        begin
            if (level[k] < lo)
                lo = level[k];
            if (level[k] > hi)
                hi = level[k];
        end
        center = (lo + hi) >>> 1;
        for (int k = 0; k < 3; k++)
        begin
            d = level[k] - center + 32768;
            if (d < longint'(pulse_reg))
                d = 0;
            else if (d > 65536 - longint'(pulse_reg))
                d = 65536;
            duty[k] = d[DUTY_W-1:0];
        end
        return '{duty_a: duty[0], duty_b: duty[1], duty_c: duty[2]};
    endfunction

    function automatic void enqueue(logic [ANGLE_BITS-1:0] ang);
        angle_backlog.push_back(ang);
        angles_issued++;
    endfunction

    function automatic void add_random(int n);
        for (int i = 0; i < n; i++)
            enqueue(ANGLE_BITS'($urandom_range(0, 65535)));
    endfunction

    // one register write transaction, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AMP_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_AMPLITUDE)
            amp_reg = val;
        else
            pulse_reg = val;
    endtask

    task automatic wait_drained();
        while (duties_seen != angles_issued)
            @(posedge clk);
    endtask

    function automatic logic [AMP_W-1:0] random_pulse();
        if ($urandom_range(0, 3) == 0)
            return AMP_W'($urandom_range(0, PULSE_MAX));
        return AMP_W'($urandom_range(0, 4000));
    endfunction

    task automatic check_duty(input string field, input logic [DUTY_W-1:0] want,
                              input logic [DUTY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // angle driver: offers backlog items, holds while full, idles in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            angle    <= '0;
            send_gap =  0;
        end
        else
        begin
            if (push && !full)
                duty_expect.push_back(predict_duty(angle));
            if (push && full)
            begin
                // offer stays until the block takes it
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 8);
                push     <= 1'b0;
            end
            else if (angle_backlog.size() > 0)
            begin
                push  <= 1'b1;
                angle <= angle_backlog.pop_front();
            end
            else
                push <= 1'b0;
        end
    end

    // duty monitor: checks each popped transaction, stalls in bursts
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            pop          <= 1'b0;
            pop_gap      =  0;
            backlog_hold =  0;
        end
        else
        begin
            if (pop && !empty)
            begin
                duties_seen++;
                if (duty_expect.size() == 0)
                begin
                    $display("%0t: unexpected duty transaction, expected none, actual %0d %0d %0d",
                             $time, duty_a, duty_b, duty_c);
                    fail_count++;
                end
                else
                begin
                    want = duty_expect.pop_front();
                    check_duty("duty_a", want.duty_a, duty_a);
                    check_duty("duty_b", want.duty_b, duty_b);
                    check_duty("duty_c", want.duty_c, duty_c);
                end
                // one long stall so the block backs up and raises full
                if (duties_seen == HOLD_AT)
                    backlog_hold = HOLD_CYCLES;
            end
            if (backlog_hold > 0)
            begin
                backlog_hold--;
                pop <= 1'b0;
            end
            else if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                pop_gap = $urandom_range(0, 8);
                pop     <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[svpwm_three_phase_duty] ERROR");
            $finish;
        end
    end

    // stimulus and phase sequencing
    initial
    begin
        for (int i = 0; i <= TAB_Q; i++)
            quarter_wave[i] = $rtoi(32767.0 * $sin(HALF_PI * real'(i) / real'(TAB_Q)) + 0.5);
        edge_angles = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000,
                        16'h5555, 16'hAAAA, 16'h001F, 16'h0020, 16'h2AAA, 16'hD555};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: zero amplitude, every duty at mid scale
        for (int i = 0; i < 4; i++)
            enqueue(edge_angles[i]);
        wait_drained();

        // full overmodulation, no pulse limit
        write_reg(REG_AMPLITUDE, AMP_W'(AMP_MAX));
        write_reg(REG_MIN_PULSE, '0);
        foreach (edge_angles[i])
            enqueue(edge_angles[i]);
        add_random(60);
        wait_drained();

        // nominal full sine with a modest pulse limit
        write_reg(REG_AMPLITUDE, AMP_W'(32767));
        write_reg(REG_MIN_PULSE, AMP_W'(1000));
        add_random(150);
        wait_drained();

        // widest pulse limit: duties snap to zero, full or mid scale
        write_reg(REG_MIN_PULSE, AMP_W'(PULSE_MAX));
        for (int i = 0; i < 6; i++)
            enqueue(edge_angles[i]);
        add_random(60);
        wait_drained();

        // long run that spans the receiver stall
        write_reg(REG_AMPLITUDE, AMP_W'(20000));
        write_reg(REG_MIN_PULSE, AMP_W'(2500));
        add_random(220);
        wait_drained();

        // zero amplitude against the widest pulse limit
        write_reg(REG_AMPLITUDE, '0);
        write_reg(REG_MIN_PULSE, AMP_W'(PULSE_MAX));
        add_random(30);
        wait_drained();

        // random settings
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_AMPLITUDE, AMP_W'($urandom_range(0, AMP_MAX)));
            write_reg(REG_MIN_PULSE, random_pulse());
            add_random(60);
            wait_drained();
        end

        // closing stretch at full rate on both sides
        write_reg(REG_AMPLITUDE, AMP_W'($urandom_range(AMP_MAX / 2, AMP_MAX)));
        write_reg(REG_MIN_PULSE, random_pulse());
        no_idle <= 1'b1;
        add_random(170);
        wait_drained();

        repeat (SETTLE) @(posedge clk);
        if (duty_expect.size() != 0)
        begin
            $display("%0t: %0d duty transactions expected, 0 received", $time,
                     duty_expect.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("[svpwm_three_phase_duty] OK");
        else
            $display("[svpwm_three_phase_duty] ERROR");
        $finish;
    end

endmodule
